>>> hdl/oal_pkg.sv
// Package for the ordered array list: operation and status codes, payload
// structs for both channels and the control bundle sent down the cell chain.
// No dependencies.
package oal_pkg;

  localparam int DEF_CAPACITY = 32;
  localparam int DATA_W       = 32;
  localparam int POS_W        = 6;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_FIND   = 2'd2,
    OP_READ   = 2'd3
  } op_e_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_e_t;

  typedef struct packed {
    op_e_t                     op;
    logic [POS_W-1:0]          position;
    logic signed [DATA_W-1:0]  item_value;
  } in_item_t;

  typedef struct packed {
    status_e_t                 status;
    logic [POS_W-1:0]          found_at;
    logic signed [DATA_W-1:0]  read_value;
    logic [POS_W-1:0]          count;
  } out_item_t;

  // Broadcast to every cell. The slot is the zero-based list position.
  typedef struct packed {
    logic                      ins;
    logic                      del;
    logic [POS_W-1:0]          slot;
    logic signed [DATA_W-1:0]  value;
  } oal_ctrl_t;

endpackage

>>> hdl/oal_cell.sv
// One storage cell of the ordered array list chain.
// Depends on oal_pkg for the control bundle and data width.
module oal_cell
  import oal_pkg::*;
#(
  parameter int INDEX = 0
) (
  input  logic                      clk,
  input  oal_ctrl_t                 ctrl,
  input  logic signed [DATA_W-1:0]  left_q,
  input  logic signed [DATA_W-1:0]  right_q,
  output logic signed [DATA_W-1:0]  data_q,
  output logic                      hit
);

  logic signed [DATA_W-1:0] data_r;
  logic signed [DATA_W-1:0] data_nxt;

  // Insert: the chosen cell loads the new value and later cells take their
  // left neighbor. Delete: the chosen cell and later cells take their right
  // neighbor.
  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins) begin
      if (INDEX == int'(ctrl.slot)) begin
        data_nxt = ctrl.value;
      end else if (INDEX > int'(ctrl.slot)) begin
        data_nxt = left_q;
      end
    end else if (ctrl.del) begin
      if (INDEX >= int'(ctrl.slot)) begin
        data_nxt = right_q;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_q = data_r;
  assign hit    = (data_r == ctrl.value);

endmodule

>>> hdl/oal_ctrl.sv
// Operation decode for the ordered array list: position checks, status and
// the control bundle for the cell chain. Depends on oal_pkg.
module oal_ctrl
  import oal_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY,
  parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
  input  logic              accept,
  input  in_item_t          item,
  input  logic [CNT_W-1:0]  count,
  output oal_ctrl_t         ctrl,
  output status_e_t         status
);

  localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  logic [CMP_W-1:0] pos_x;
  logic [CMP_W-1:0] cnt_x;
  logic             pos_zero;
  logic             ins_bad;
  logic             acc_bad;
  logic             is_full;

  assign pos_x    = CMP_W'(item.position);
  assign cnt_x    = CMP_W'(count);
  assign pos_zero = (item.position == '0);
  assign ins_bad  = pos_zero || (pos_x > cnt_x + CMP_W'(1));
  assign acc_bad  = pos_zero || (pos_x > cnt_x);
  assign is_full  = (cnt_x >= CMP_W'(CAPACITY));

  always_comb begin
    status = ST_OK;
    case (item.op)
      OP_INSERT: begin
        if (ins_bad) begin
          status = ST_BADPOS;
        end else if (is_full) begin
          status = ST_FULL;
        end
      end
      OP_DELETE, OP_READ: begin
        if (acc_bad) begin
          status = ST_BADPOS;
        end
      end
      default: status = ST_OK;
    endcase
  end

  assign ctrl.ins   = accept && (item.op == OP_INSERT) && (status == ST_OK);
  assign ctrl.del   = accept && (item.op == OP_DELETE) && (status == ST_OK);
  assign ctrl.slot  = item.position - POS_W'(1);
  assign ctrl.value = item.item_value;

endmodule

>>> hdl/ordered_array_list.sv
// Top level of the ordered array list: a chain of storage cells, the
// operation decode, the entry counter and the result register.
// Depends on oal_pkg, oal_ctrl and oal_cell.
//
// Usage: drive in_item and raise start; a command transfers at a rising
// edge with start high and busy low. busy stays low, so a new command may
// be issued in every cycle. Each command gives exactly one result: out_valid
// is high for one cycle, in the cycle after the transfer, with out_item holding
// status, found_at, read_value and the count after the command.
// Insert and delete move all entries at once in the cell chain; find compares
// every cell against the key in parallel and a priority pick returns the
// lowest matching position; read selects one cell.
// The receiver cannot stall; a result must be taken in its strobe cycle.
// Reset clears the entry count and the result strobe; cell contents are not
// cleared, and only positions 1 to count are ever visible.
module ordered_array_list
  import oal_pkg::*;
#(
  parameter int CAPACITY = DEF_CAPACITY
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  in_item_t   in_item,
  output logic       out_valid,
  output out_item_t  out_item
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  logic                      accept;
  oal_ctrl_t                 ctrl;
  status_e_t                 status;
  logic [CNT_W-1:0]          count_r;
  logic [CNT_W-1:0]          count_nxt;
  logic signed [DATA_W-1:0]  cell_q [CAPACITY];
  logic [CAPACITY-1:0]       hit;
  logic [CAPACITY-1:0]       live_hit;
  logic [CNT_W-1:0]          found;
  logic                      out_valid_r;
  out_item_t                 out_item_r;
  out_item_t                 out_item_nxt;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  oal_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .accept (accept),
    .item   (in_item),
    .count  (count_r),
    .ctrl   (ctrl),
    .status (status)
  );

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [DATA_W-1:0] left_q;
    logic signed [DATA_W-1:0] right_q;

    // The chain ends feed back their own value; those inputs are never selected
    // for a live entry.
    assign left_q  = (g == 0) ? cell_q[g] : cell_q[(g == 0) ? 0 : g - 1];
    assign right_q = (g == CAPACITY - 1) ? cell_q[g]
                                         : cell_q[(g == CAPACITY - 1) ? g : g + 1];

    oal_cell #(
      .INDEX (g)
    ) u_cell (
      .clk     (clk),
      .ctrl    (ctrl),
      .left_q  (left_q),
      .right_q (right_q),
      .data_q  (cell_q[g]),
      .hit     (hit[g])
    );

    assign live_hit[g] = hit[g] && (CNT_W'(g) < count_r);
  end

  // Lowest live match wins.
  always_comb begin
    found = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (live_hit[i]) begin
        found = CNT_W'(i + 1);
      end
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (ctrl.ins) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (ctrl.del) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_comb begin
    out_item_nxt.status     = status;
    out_item_nxt.found_at   = '0;
    out_item_nxt.read_value = '0;
    out_item_nxt.count      = POS_W'(count_nxt);
    if (in_item.op == OP_FIND) begin
      out_item_nxt.found_at = POS_W'(found);
    end
    if ((in_item.op == OP_READ) && (status == ST_OK)) begin
      out_item_nxt.read_value = cell_q[IDX_W'(ctrl.slot)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_item_r <= out_item_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

>>> bench/tb_ordered_array_list.sv
// Self-checking testbench for the ordered array list: directed corner commands, then
// random command streams biased to fill, churn and empty the list, checked in order.
// Depends on oal_pkg and the ordered_array_list top level.
module tb_ordered_array_list;
  import oal_pkg::*;

  localparam int WATCHDOG_LIMIT = 2000;

  // Tracks the expected list contents and the results still owed by the block.
  class list_scoreboard;
    logic signed [DATA_W-1:0] slots [DEF_CAPACITY];
    int                       n_entries = 0;
    int unsigned              n_errors  = 0;
    out_item_t                expected_q[$];

    function void note_command(in_item_t cmd);
      out_item_t r;
      int        i;
      int        p;
      r        = '0;
      r.status = ST_OK;
      p        = int'(cmd.position);
      case (cmd.op)
        OP_INSERT: begin
          // A bad position wins over a full list.
          if (p < 1 || p > n_entries + 1) begin
            r.status = ST_BADPOS;
          end else if (n_entries >= DEF_CAPACITY) begin
            r.status = ST_FULL;
          end else begin
            for (i = n_entries; i >= p; i--) slots[i] = slots[i-1];
            slots[p-1] = cmd.item_value;
            n_entries++;
          end
        end
        OP_DELETE: begin
          if (p < 1 || p > n_entries) begin
            r.status = ST_BADPOS;
          end else begin
            for (i = p; i < n_entries; i++) slots[i-1] = slots[i];
            n_entries--;
          end
        end
        OP_FIND: begin
          for (i = 0; i < n_entries; i++) begin
            if (r.found_at == 0 && slots[i] == cmd.item_value) r.found_at = POS_W'(i + 1);
          end
        end
        default: begin
          if (p < 1 || p > n_entries) r.status = ST_BADPOS;
          else r.read_value = slots[p-1];
        end
      endcase
      r.count = POS_W'(n_entries);
      expected_q.push_back(r);
    endfunction

    function void check_result(out_item_t got);
      out_item_t exp_r;
      if (expected_q.size() == 0) begin
        $error("result with no command outstanding: status %0d count %0d",
               got.status, got.count);
        n_errors++;
      end else begin
        exp_r = expected_q.pop_front();
        if (got.status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, got.status);
          n_errors++;
        end
        if (got.found_at !== exp_r.found_at) begin
          $error("found_at: expected %0d, got %0d", exp_r.found_at, got.found_at);
          n_errors++;
        end
        if (got.read_value !== exp_r.read_value) begin
          $error("read_value: expected %0d, got %0d", exp_r.read_value, got.read_value);
          n_errors++;
        end
        if (got.count !== exp_r.count) begin
          $error("count: expected %0d, got %0d", exp_r.count, got.count);
          n_errors++;
        end
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  list_scoreboard sb;
  int             idle_cycles = 0;

  ordered_array_list u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always #10 clk = ~clk;

  // Results cannot be held off, so every strobe is checked at the edge that ends it.
  always @(posedge clk) begin
    if (rst_n && out_valid) sb.check_result(out_item);
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  // Holds start high until the command transfers, then records it.
  task automatic send_cmd(input in_item_t cmd);
    start   <= 1'b1;
    in_item <= cmd;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_command(cmd);
  endtask

  task automatic send_op(input op_e_t op, input int pos, input logic [DATA_W-1:0] val);
    in_item_t cmd;
    cmd.op         = op;
    cmd.position   = POS_W'(pos);
    cmd.item_value = val;
    send_cmd(cmd);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  // Mostly legal positions against the current list, with some out-of-range noise.
  function automatic in_item_t pick_command(int insert_weight);
    in_item_t cmd;
    int       n;
    n = sb.n_entries;
    if ($urandom_range(99) < insert_weight) begin
      cmd.op = OP_INSERT;
    end else begin
      case ($urandom_range(2))
        0:       cmd.op = OP_DELETE;
        1:       cmd.op = OP_FIND;
        default: cmd.op = OP_READ;
      endcase
    end
    if ($urandom_range(7) == 0) cmd.position = POS_W'($urandom_range(63));
    else if (cmd.op == OP_INSERT) cmd.position = POS_W'($urandom_range(1, n + 1));
    else if (n > 0) cmd.position = POS_W'($urandom_range(1, n));
    else cmd.position = POS_W'($urandom_range(63));
    // Small values give duplicates, so find has to return the first match.
    case ($urandom_range(3))
      0: cmd.item_value = $urandom;
      1: cmd.item_value = $urandom_range(7);
      2: begin
        case ($urandom_range(3))
          0:       cmd.item_value = 32'h8000_0000;
          1:       cmd.item_value = 32'h7fff_ffff;
          2:       cmd.item_value = 32'h0000_0000;
          default: cmd.item_value = 32'hffff_ffff;
        endcase
      end
      default: begin
        if (n > 0) cmd.item_value = sb.slots[$urandom_range(n - 1)];
        else cmd.item_value = $urandom;
      end
    endcase
    return cmd;
  endfunction

  initial begin
    int phase;
    int k;
    int burst_left;
    int weight;
    sb      = new();
    rst_n   = 1'b0;
    start   = 1'b0;
    in_item = '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // Empty-list cases, bad and good inserts at the front, middle and end, then reads, finds and deletes.
    send_op(OP_FIND, 0, 32'h0);
    send_op(OP_DELETE, 1, 32'h0);
    send_op(OP_READ, 1, 32'h0);
    send_op(OP_INSERT, 0, 32'h1);
    send_op(OP_INSERT, 2, 32'h1);
    send_op(OP_INSERT, 1, 32'h7fff_ffff);
    send_op(OP_INSERT, 1, 32'h8000_0000);
    send_op(OP_INSERT, 3, 32'hffff_ffff);
    send_op(OP_INSERT, 2, 32'h5);
    send_op(OP_INSERT, 63, 32'h9);
    send_op(OP_READ, 0, 32'h0);
    for (k = 1; k <= 5; k++) send_op(OP_READ, k, 32'hffff_ffff);
    send_op(OP_FIND, 0, 32'h7fff_ffff);
    send_op(OP_FIND, 63, 32'd123);
    send_op(OP_INSERT, 2, 32'h5);
    send_op(OP_FIND, 0, 32'h5);
    send_op(OP_DELETE, 0, 32'h0);
    send_op(OP_DELETE, 63, 32'h0);
    send_op(OP_DELETE, 1, 32'h0);
    send_op(OP_DELETE, 4, 32'h0);
    send_op(OP_READ, 1, 32'h0);
    wait_drained();

    // Phases alternate between filling past capacity, churning and emptying.
    burst_left = $urandom_range(1, 24);
    for (phase = 0; phase < 8; phase++) begin
      case (phase % 4)
        0:       weight = 75;
        1:       weight = 30;
        2:       weight = 8;
        default: weight = 45;
      endcase
      for (k = 0; k < 250; k++) begin
        if (burst_left == 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 8)) @(posedge clk);
          burst_left = ($urandom_range(9) == 0) ? 150 : $urandom_range(1, 24);
        end
        send_cmd(pick_command(weight));
        burst_left--;
      end
      wait_drained();
    end

    repeat (4) @(posedge clk);
    if (sb.pending() != 0) $error("%0d results never arrived", sb.pending());
    if (sb.n_errors == 0 && sb.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
